/* hdl/oxfp_pkg.sv */
package oxfp_pkg;

    localparam int MAX_FRAME_BYTES = 20;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);

    localparam int NUM_REGS = 7;
    localparam int NUM_KINDS = 6;

    // configuration register indexes
    localparam logic [2:0] REG_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_CODE_FIRST = 3'd1;

    // frame kinds
    localparam logic [2:0] KIND_MEAS    = 3'd0;
    localparam logic [2:0] KIND_AVERAGE = 3'd1;
    localparam logic [2:0] KIND_VERSION = 3'd2;
    localparam logic [2:0] KIND_PART    = 3'd3;
    localparam logic [2:0] KIND_SELF    = 3'd4;
    localparam logic [2:0] KIND_MAKER   = 3'd5;
    localparam logic [2:0] KIND_NONE    = 3'd7;

    // measurement frame: flag/status bytes 11..18 are kept in registers
    localparam int FB_FIRST = 11;
    localparam int FB_LAST  = 18;
    localparam int FB_NUM   = FB_LAST - FB_FIRST + 1;

    localparam logic [3:0] MEAS_LAST_IDX = 4'd9;

    typedef logic [7:0] t_byte;

    function automatic logic [CNT_W-1:0] frame_len(input logic [2:0] kind);
        logic [CNT_W-1:0] len;
        case (kind)
            KIND_MEAS:    len = CNT_W'(20);
            KIND_AVERAGE: len = CNT_W'(3);
            KIND_VERSION: len = CNT_W'(3);
            KIND_PART:    len = CNT_W'(10);
            KIND_SELF:    len = CNT_W'(3);
            KIND_MAKER:   len = CNT_W'(18);
            default:      len = CNT_W'(MAX_FRAME_BYTES);
        endcase
        return len;
    endfunction

    // index of the final result of a good frame
    function automatic logic [3:0] last_index(input logic [2:0] kind);
        logic [CNT_W-1:0] len;
        len = frame_len(kind);
        if (kind == KIND_MEAS) begin
            return MEAS_LAST_IDX;
        end
        return 4'(len - CNT_W'(3));
    endfunction

endpackage

/* hdl/oximeter_frame_parser.sv */
// Pulse-oximeter serial frame parser. Bytes come in on i_rx_byte with a
// valid/ready handshake; a byte at or above the command threshold opens a
// frame whose kind is chosen by the code registers (first match wins).
// Frame bytes go into a 20-entry store with a running 7-bit checksum.
// A byte that does not complete a frame leaves o_ready high. When the
// final byte arrives the block drops o_ready and its sequencer walks the
// store through its single registered read port: each result is read,
// then presented and held until i_ready, so a good measurement frame
// gives 10 results, a maker frame 16, and a bad checksum one result,
// presented with no read. Config writes on i_cfg_* take effect at once
// and are meant to be done while idle.
module oximeter_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  oxfp_pkg::t_byte       i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  oxfp_pkg::t_byte       i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_frame_kind,
    output logic                  o_checksum_ok,
    output logic [3:0]            o_item_index,
    output logic [7:0]            o_data_byte,
    output logic [6:0]            o_spo2_percent,
    output logic [7:0]            o_pulse_rate,
    output logic [3:0]            o_sensor_state,
    output logic [1:0]            o_noise_level,
    output logic [3:0]            o_pulse_bar,
    output logic [7:0]            o_perfusion,
    output logic                  o_last
);
    import oxfp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]       r_state, n_state;
    t_byte            r_cfg [0:NUM_REGS-1];
    t_byte            r_mem [0:MAX_FRAME_BYTES-1];
    t_byte            r_rdata;
    t_byte            r_fb [0:FB_NUM-1];
    logic [CNT_W-1:0] r_count;
    logic [2:0]       r_kind;
    logic             r_done;
    logic [6:0]       r_sum;
    logic             r_ok;
    logic [3:0]       r_idx;

    logic             in_acc, is_cmd, take_data, completes, out_acc, at_last;
    logic [2:0]       dec_kind;
    logic [CNT_W-1:0] count_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic [3:0]       idx_last;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign is_cmd  = (i_rx_byte >= r_cfg[REG_THRESHOLD]);
    assign take_data = !is_cmd && !r_done && (r_kind != KIND_NONE)
                       && (r_count < CNT_W'(MAX_FRAME_BYTES));
    assign count_inc = r_count + CNT_W'(1);
    assign completes = take_data && (count_inc >= frame_len(r_kind));
    assign idx_last  = last_index(r_kind);
    assign at_last   = (r_idx == idx_last);
    assign rd_addr   = ADDR_W'(r_idx) + ADDR_W'(1);

    always_comb begin
        dec_kind = KIND_NONE;
        for (int k = NUM_KINDS - 1; k >= 0; k--) begin
            if (r_cfg[int'(REG_CODE_FIRST) + k] == i_rx_byte) begin
                dec_kind = 3'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && completes) begin
                    n_state = (r_sum == i_rx_byte[6:0]) ? S_READ : S_OUT;
                end
            end
            S_READ: n_state = S_OUT;
            S_OUT: begin
                if (out_acc) begin
                    n_state = (o_last) ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_kind  <= KIND_NONE;
            r_done  <= 1'b1;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= 8'(128 + i);
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_idx < 3'(NUM_REGS))) begin
                r_cfg[i_cfg_idx] <= i_cfg_wdata;
            end
            if (in_acc) begin
                if (is_cmd) begin
                    r_count <= CNT_W'(1);
                    r_kind  <= dec_kind;
                    r_done  <= (dec_kind == KIND_NONE);
                end else if (take_data) begin
                    r_count <= count_inc;
                    if (completes) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // payload side: store, running checksum, result index
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (in_acc) begin
            if (is_cmd) begin
                r_mem[0] <= i_rx_byte;
                r_sum    <= i_rx_byte[6:0];
            end else if (take_data) begin
                r_mem[r_count[ADDR_W-1:0]] <= i_rx_byte;
                r_sum <= r_sum + i_rx_byte[6:0];
                if (r_count >= CNT_W'(FB_FIRST) && r_count <= CNT_W'(FB_LAST)) begin
                    r_fb[3'(r_count - CNT_W'(FB_FIRST))] <= i_rx_byte;
                end
                if (completes) begin
                    r_ok  <= (r_sum == i_rx_byte[6:0]);
                    r_idx <= '0;
                end
            end
        end
        if (r_state == S_OUT && out_acc && !o_last) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    // measurement fields from bytes 11..18
    t_byte      b11, b12, b13, b14, b15, b16, b17, b18;
    logic       meas;
    logic [6:0] spo2_raw;
    logic [7:0] pr_raw;
    logic [3:0] st_code;
    logic       wave_flag;

    assign b11 = r_fb[0];
    assign b12 = r_fb[1];
    assign b13 = r_fb[2];
    assign b14 = r_fb[3];
    assign b15 = r_fb[4];
    assign b16 = r_fb[5];
    assign b17 = r_fb[6];
    assign b18 = r_fb[7];

    assign meas     = r_ok && (r_kind == KIND_MEAS);
    assign spo2_raw = b15[6:0];
    assign pr_raw   = {b13[5], b14[6:0]};

    always_comb begin
        st_code = 4'd0;
        if (b13[4]) begin
            st_code = 4'd12;
        end
        for (int i = 5; i >= 2; i--) begin
            if (b17[i]) begin
                st_code = 4'(i + 6);
            end
        end
        for (int i = 6; i >= 0; i--) begin
            if (b16[i]) begin
                st_code = 4'(i + 1);
            end
        end
    end

    always_comb begin
        if (r_idx < 4'd7) begin
            wave_flag = b11[r_idx[2:0]];
        end else begin
            wave_flag = b12[2'(r_idx - 4'd7)];
        end
    end

    assign o_valid       = (r_state == S_OUT);
    assign o_frame_kind  = r_kind;
    assign o_checksum_ok = r_ok;
    assign o_item_index  = r_idx;
    assign o_last        = !r_ok || at_last;

    always_comb begin
        o_data_byte    = 8'd0;
        o_spo2_percent = 7'd0;
        o_pulse_rate   = 8'd0;
        o_sensor_state = 4'd0;
        o_noise_level  = 2'd0;
        o_pulse_bar    = 4'd0;
        o_perfusion    = 8'd0;
        if (r_ok) begin
            o_data_byte = r_rdata;
        end
        if (meas) begin
            // sample high bit is the data bit XOR a flag bit from bytes 11/12
            o_data_byte = {r_rdata[7] ^ wave_flag, r_rdata[6:0]};
            if (spo2_raw > 7'd100) begin
                o_spo2_percent = 7'd100;
            end else if (spo2_raw >= 7'd30) begin
                o_spo2_percent = spo2_raw;
            end
            if (pr_raw > 8'd240) begin
                o_pulse_rate = 8'd240;
            end else if (pr_raw >= 8'd30) begin
                o_pulse_rate = pr_raw;
            end
            o_sensor_state = st_code;
            o_noise_level  = b17[1:0];
            o_pulse_bar    = b13[3:0];
            o_perfusion    = {b18[7] ^ b17[6], b18[6:0]};
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input open while a result is pending");

    a_bad_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_checksum_ok) |-> (o_last && o_item_index == 4'd0))
        else $error("bad checksum result not a single last word");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> o_ready)
        else $error("block not ready after final result");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> ##1 (o_valid
            && o_item_index == $past(o_item_index, 2) + 4'd1))
        else $error("result index did not advance by one");

    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_kind < 3'(NUM_KINDS)))
        else $error("result for a frame with no kind");

endmodule
